// ===== design/weighted_completion_scheduler_defines.svh =====
// Assertion macros shared by the checker of the weighted completion scheduler.
`ifndef WEIGHTED_COMPLETION_SCHEDULER_DEFINES_SVH
`define WEIGHTED_COMPLETION_SCHEDULER_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define WCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define WCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/wcs_pkg.sv =====
// Package with types and constants of the weighted completion scheduler.
`timescale 1ns / 1ps
`default_nettype none
package wcs_pkg;
    localparam int MaxJobsDefault = 64;
    localparam int DurW  = 16;
    localparam int CostW = 16;
    localparam int KeyW  = 16;
    localparam int IdW   = 7;
    localparam int FinW  = 22;
    localparam int TotW  = 48;

    typedef enum logic [2:0] {
        t_ST_LOAD,
        t_ST_KEY,
        t_ST_SCAN,
        t_ST_PICK,
        t_ST_EMIT,
        t_ST_MUL
    } t_state;
endpackage
`default_nettype wire

// ===== design/wcs_divider.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wcs_divider (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_go,
    input  wire logic [wcs_pkg::CostW-1:0] i_num,
    input  wire logic [wcs_pkg::DurW-1:0]  i_den,
    output logic                           o_done,
    output logic [wcs_pkg::KeyW-1:0]       o_quot
);
    import wcs_pkg::*;

    logic [DurW:0]    r_rem, n_rem;
    logic [CostW-1:0] r_q, n_q;
    logic [DurW-1:0]  r_den;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic [DurW:0]    w_sh;

    always_comb begin
        w_sh  = {r_rem[DurW-1:0], r_q[CostW-1]};
        n_q   = {r_q[CostW-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem   = w_sh - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(CostW);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '1 : r_q;
endmodule
`default_nettype wire

// ===== design/weighted_completion_scheduler.sv =====
// Top level of the weighted completion scheduler.
// Jobs are loaded with start while busy is low, one transfer per cycle;
// up to MAX_JOBS are stored and further ones are dropped.
// A job with i_last_job set starts scheduling and raises busy.
// For each stored job a serial divider forms cost / duration
// (all ones for a zero duration), with launch and write-back per job.
// Selection then scans the key memory once per result and passes through
// the PICK, MUL and EMIT states to fetch, accumulate and emit a result,
// choosing the largest key and the later arrival among equal keys.
// Each result is presented for one cycle with o_valid; the receiver cannot
// stall, so results are simply driven.
// Reset is synchronous and active low; it empties the job count and returns
// the block to loading. Stores hold no reset value.
`timescale 1ns / 1ps
`default_nettype none
module weighted_completion_scheduler #(
    parameter int MAX_JOBS = wcs_pkg::MaxJobsDefault
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [wcs_pkg::DurW-1:0]  i_duration,
    input  wire logic [wcs_pkg::CostW-1:0] i_cost_per_day,
    input  wire logic                      i_last_job,
    output logic                           o_valid,
    output logic [wcs_pkg::IdW-1:0]        o_job_id,
    output logic [wcs_pkg::FinW-1:0]       o_finish_time,
    output logic [wcs_pkg::TotW-1:0]       o_running_cost,
    output logic                           o_last_result
);
    import wcs_pkg::*;

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [DurW-1:0]  mem_dur  [MAX_JOBS];
    logic [CostW-1:0] mem_cost [MAX_JOBS];
    logic [KeyW-1:0]  mem_key  [MAX_JOBS];
    logic [MAX_JOBS-1:0] r_done_mask;

    t_state r_st, n_st;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic          r_rd_v;
    logic [AW-1:0] r_rd_idx;
    logic [CW-1:0] r_emitted;
    logic          r_have;
    logic [AW-1:0] r_best;
    logic [KeyW-1:0] r_best_key;
    logic [DurW-1:0]  r_dur_q;
    logic [CostW-1:0] r_cost_q;
    logic [KeyW-1:0]  r_key_q;
    logic [FinW-1:0]  r_fin;
    logic [TotW-1:0]  r_tot;
    logic          r_div_go, r_div_wait;
    logic          div_done;
    logic [KeyW-1:0] div_q;

    logic w_accept;
    assign w_accept = start && !busy;

    wcs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_cost_q),
        .i_den   (r_dur_q),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    logic [AW-1:0] w_ra;
    always_comb begin
        w_ra = r_idx[AW-1:0];
        if (r_st == t_ST_PICK || r_st == t_ST_EMIT || r_st == t_ST_MUL) begin
            w_ra = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_cnt < CW'(MAX_JOBS)) begin
            mem_dur[r_cnt[AW-1:0]]  <= i_duration;
            mem_cost[r_cnt[AW-1:0]] <= i_cost_per_day;
        end
        if (r_st == t_ST_KEY && div_done) begin
            mem_key[r_idx[AW-1:0]] <= div_q;
        end
        r_dur_q  <= mem_dur[w_ra];
        r_cost_q <= mem_cost[w_ra];
        r_key_q  <= mem_key[w_ra];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            t_ST_LOAD: if (w_accept && i_last_job) n_st = (r_cnt == '0 &&
                           MAX_JOBS == 0) ? t_ST_LOAD : t_ST_KEY;
            t_ST_KEY:  if (div_done && r_idx + CW'(1) == r_cnt) n_st = t_ST_SCAN;
            t_ST_SCAN: if (!r_rd_v && r_idx == r_cnt) n_st = t_ST_PICK;
            t_ST_PICK: n_st = t_ST_MUL;
            t_ST_MUL:  n_st = t_ST_EMIT;
            t_ST_EMIT: n_st = (r_emitted + CW'(1) == r_cnt) ? t_ST_LOAD : t_ST_SCAN;
            default:   n_st = t_ST_LOAD;
        endcase
    end

    always_comb begin
        busy = (r_st != t_ST_LOAD);
    end

    logic [CW-1:0] w_cnt_after;
    assign w_cnt_after = (r_cnt < CW'(MAX_JOBS)) ? r_cnt + CW'(1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= t_ST_LOAD;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_rd_v     <= 1'b0;
            r_div_go   <= 1'b0;
            r_div_wait <= 1'b0;
            r_emitted  <= '0;
            r_have     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
            unique case (r_st)
                t_ST_LOAD: begin
                    if (w_accept) begin
                        r_cnt <= w_cnt_after;
                        if (i_last_job) begin
                            r_idx       <= '0;
                            r_div_wait  <= 1'b0;
                            r_emitted   <= '0;
                            r_fin       <= '0;
                            r_tot       <= '0;
                            r_done_mask <= '0;
                            r_have      <= 1'b0;
                            r_rd_v      <= 1'b0;
                        end
                    end
                end
                t_ST_KEY: begin
                    if (!r_div_wait) begin
                        r_div_wait <= 1'b1;
                        r_div_go   <= 1'b1;
                    end else if (div_done) begin
                        r_div_wait <= 1'b0;
                        if (r_idx + CW'(1) == r_cnt) begin
                            r_idx <= '0;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                t_ST_SCAN: begin
                    r_rd_v   <= (r_idx != r_cnt);
                    r_rd_idx <= r_idx[AW-1:0];
                    if (r_idx != r_cnt) r_idx <= r_idx + CW'(1);
                    if (r_rd_v && !r_done_mask[r_rd_idx] &&
                        (!r_have || r_key_q >= r_best_key)) begin
                        r_have     <= 1'b1;
                        r_best     <= r_rd_idx;
                        r_best_key <= r_key_q;
                    end
                end
                t_ST_PICK: begin
                    r_rd_v <= 1'b0;
                end
                t_ST_MUL: begin
                    r_fin <= r_fin + FinW'(r_dur_q);
                end
                t_ST_EMIT: begin
                    r_tot  <= r_tot + TotW'(r_fin * (FinW+CostW)'(r_cost_q));
                    o_valid        <= 1'b1;
                    o_job_id       <= IdW'(r_best) + IdW'(1);
                    o_finish_time  <= r_fin;
                    o_running_cost <= r_tot + TotW'(r_fin * (FinW+CostW)'(r_cost_q));
                    o_last_result  <= (r_emitted + CW'(1) == r_cnt);
                    r_done_mask[r_best] <= 1'b1;
                    r_emitted <= r_emitted + CW'(1);
                    r_have    <= 1'b0;
                    r_idx     <= '0;
                    if (r_emitted + CW'(1) == r_cnt) r_cnt <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/wcs_checker.sv =====
// Port-level assertion checker for the weighted completion scheduler.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_completion_scheduler_defines.svh"
module wcs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       i_last_job,
    input wire logic       o_valid,
    input wire logic       o_last_result,
    input wire logic [6:0] o_job_id
);
    `WCS_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, start && !busy && i_last_job, busy)
    `WCS_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid && !o_last_result, busy)
    `WCS_ASSERT_NXT(a_last_frees, i_clk, i_rst_n, o_valid && o_last_result, !o_valid)
    `WCS_ASSERT_IMP(a_id_range, i_clk, i_rst_n, o_valid, o_job_id != 7'd0)
endmodule

bind weighted_completion_scheduler wcs_checker u_wcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_last_job    (i_last_job),
    .o_valid       (o_valid),
    .o_last_result (o_last_result),
    .o_job_id      (o_job_id)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the weighted completion scheduler.
`timescale 1ns / 1ps
`default_nettype none

class wcs_scoreboard;
    logic [15:0] dur_q[$];
    logic [15:0] cost_q[$];
    logic [6:0]  exp_id[$];
    logic [21:0] exp_fin[$];
    logic [47:0] exp_tot[$];
    logic        exp_last[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return exp_id.size();
    endfunction

    // Notes an accepted job and, for the last job of a set, predicts the schedule.
    function void note_job(logic [15:0] dur, logic [15:0] cost, logic last_job);
        int n;
        int order[64];
        logic [15:0] key[64];
        int cur;
        int j;
        logic [21:0] fin;
        logic [47:0] tot;
        if (dur_q.size() < 64) begin
            dur_q.push_back(dur);
            cost_q.push_back(cost);
        end
        if (!last_job) return;
        n = dur_q.size();
        for (int i = 0; i < n; i++) begin
            key[i] = (dur_q[i] == 0) ? 16'hFFFF : cost_q[i] / dur_q[i];
            order[i] = i;
        end
        for (int i = 1; i < n; i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && (key[cur] > key[order[j-1]] ||
                   (key[cur] == key[order[j-1]] && cur > order[j-1]))) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        fin = 0;
        tot = 0;
        for (int i = 0; i < n; i++) begin
            fin += dur_q[order[i]];
            tot += 48'(fin) * 48'(cost_q[order[i]]);
            exp_id.push_back(7'(order[i] + 1));
            exp_fin.push_back(fin);
            exp_tot.push_back(tot);
            exp_last.push_back(i == n - 1);
        end
        dur_q.delete();
        cost_q.delete();
    endfunction

    function void check_result(logic [6:0] id, logic [21:0] fin, logic [47:0] tot,
                               logic last_res);
        if (exp_id.size() == 0) begin
            $display("%0t: unexpected result id %0d", $time, id);
            errors++;
            return;
        end
        if (id !== exp_id[0]) begin
            $display("%0t: job_id exp %0d got %0d", $time, exp_id[0], id);
            errors++;
        end
        if (fin !== exp_fin[0]) begin
            $display("%0t: finish_time exp %0d got %0d", $time, exp_fin[0], fin);
            errors++;
        end
        if (tot !== exp_tot[0]) begin
            $display("%0t: running_cost exp %0d got %0d", $time, exp_tot[0], tot);
            errors++;
        end
        if (last_res !== exp_last[0]) begin
            $display("%0t: last_result exp %0d got %0d", $time, exp_last[0], last_res);
            errors++;
        end
        void'(exp_id.pop_front());
        void'(exp_fin.pop_front());
        void'(exp_tot.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_duration;
    logic [15:0] i_cost_per_day;
    logic        i_last_job;
    logic        o_valid;
    logic [6:0]  o_job_id;
    logic [21:0] o_finish_time;
    logic [47:0] o_running_cost;
    logic        o_last_result;

    wcs_scoreboard sched_sb;
    int          idle_pct;
    longint      cycles;

    weighted_completion_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_duration(i_duration), .i_cost_per_day(i_cost_per_day),
        .i_last_job(i_last_job), .o_valid(o_valid), .o_job_id(o_job_id),
        .o_finish_time(o_finish_time), .o_running_cost(o_running_cost),
        .o_last_result(o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 3000000) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sched_sb.check_result(o_job_id, o_finish_time, o_running_cost, o_last_result);
        end
    end

    // Offers one job and waits for its transfer.
    task automatic send_job(logic [15:0] dur, logic [15:0] cost, logic last_job);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_duration <= dur;
        i_cost_per_day <= cost;
        i_last_job <= last_job;
        do @(posedge i_clk); while (busy);
        sched_sb.note_job(dur, cost, last_job);
        @(negedge i_clk);
    endtask

    task automatic send_set(int n);
        logic [15:0] d;
        logic [15:0] c;
        for (int i = 0; i < n; i++) begin
            d = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
            c = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            if ($urandom_range(9) == 0) c = {2'($urandom_range(3)), 14'h0};
            send_job(d, c, i == n - 1);
        end
    endtask

    initial begin
        sched_sb = new();
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_duration = '0;
        i_cost_per_day = '0;
        i_last_job = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_job(16'd1, 16'd0, 1'b1);
        send_job(16'hFFFF, 16'hFFFF, 1'b0);
        send_job(16'd1, 16'hFFFF, 1'b0);
        send_job(16'd2, 16'd4, 1'b0);
        send_job(16'd4, 16'd8, 1'b0);
        send_job(16'hFFFF, 16'd0, 1'b1);
        for (int i = 0; i < 66; i++) begin
            send_job(16'hFFFF - 16'(i), 16'hFFFF - 16'(i), i == 65);
        end

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 2) ? 23 : 60;
            for (int s = 0; s < 4; s++) send_set($urandom_range(1, 10));
        end
        send_set(64);
        start <= 1'b0;

        while (sched_sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sched_sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== weighted_completion_scheduler.f =====
+incdir+design
design/wcs_pkg.sv
design/wcs_divider.sv
design/weighted_completion_scheduler.sv
design/wcs_checker.sv
tb/tb_top.sv
